/* src/crbt_pkg.sv */
// Package for the circle and spoke raster generator.
// Holds field widths, reset values, register indexes, walk phases and shared structs.
// No dependencies.
`timescale 1ns / 1ps

package crbt_pkg;

    localparam int CX_W        = 11;
    localparam int R_W         = 9;
    localparam int BAND_W      = 16;
    localparam int COEF_W      = 16;
    localparam int OFS_W       = 12;
    localparam int PT_W        = 12;
    localparam int SCAN_W      = R_W + 1;
    localparam int SQ_W        = 2 * R_W;
    localparam int DIFF_W      = SQ_W + 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam logic [BAND_W-1:0]        BAND_RESET = BAND_W'(125);
    localparam logic signed [COEF_W-1:0] COS_RESET  = COEF_W'(16384);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X  = 3'd0,
        CFG_CENTER_Y  = 3'd1,
        CFG_RADIUS    = 3'd2,
        CFG_BAND_HALF = 3'd3,
        CFG_COS_Q     = 3'd4,
        CFG_SIN_Q     = 3'd5,
        CFG_OFFSET_X  = 3'd6,
        CFG_OFFSET_Y  = 3'd7
    } t_cfg_idx;

    typedef enum logic [1:0] {
        PH_CIRCLE = 2'd0,
        PH_HSPOKE = 2'd1,
        PH_VSPOKE = 2'd2,
        PH_IDLE   = 2'd3
    } t_phase;

    typedef struct packed {
        logic signed [CX_W-1:0]   center_x;
        logic signed [CX_W-1:0]   center_y;
        logic [R_W-1:0]           radius;
        logic [BAND_W-1:0]        band_half;
        logic signed [COEF_W-1:0] cos_q;
        logic signed [COEF_W-1:0] sin_q;
        logic signed [OFS_W-1:0]  offset_x;
        logic signed [OFS_W-1:0]  offset_y;
    } t_cfg;

    typedef struct packed {
        logic signed [PT_W-1:0] px;
        logic signed [PT_W-1:0] py;
        logic                   last;
    } t_point;

    typedef struct packed {
        logic   valid;
        t_point data;
    } t_push;

endpackage

/* src/crbt_queue.sv */
// Point queue between the scan front end and the transform back end.
// Register-based FIFO of QUEUE_DEPTH entries; depends on crbt_pkg.
`timescale 1ns / 1ps

module crbt_queue
    import crbt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_push             i_push,
    input  logic              i_pop,
    output t_point            o_data,
    output logic              o_empty,
    output logic [QCNT_W-1:0] o_count
);

    t_point              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic [QCNT_W-1:0]   n_count;

    always_comb begin
        n_count = r_count;
        if (i_push.valid && !i_pop) begin
            n_count = r_count + QCNT_W'(1);
        end else if (!i_push.valid && i_pop) begin
            n_count = r_count - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.data;
        end
    end

    assign o_data  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

/* src/crbt_front.sv */
// Scan front end: walk state, candidate squares and band test.
// Accepts one transaction per cycle while queue credit remains; depends on crbt_pkg.
`timescale 1ns / 1ps

module crbt_front
    import crbt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_start_req,
    input  logic [QCNT_W-1:0] i_q_count,
    output t_push             o_push
);

    t_phase                   r_phase;
    logic signed [SCAN_W-1:0] r_scan_x;
    logic signed [SCAN_W-1:0] r_scan_y;

    t_phase                   cur_phase;
    logic signed [SCAN_W-1:0] cur_x;
    logic signed [SCAN_W-1:0] cur_y;
    t_phase                   n_phase;
    logic signed [SCAN_W-1:0] n_scan_x;
    logic signed [SCAN_W-1:0] n_scan_y;
    logic signed [SCAN_W-1:0] rad;
    logic                     fin;
    logic                     accept;
    logic [QCNT_W:0]          credit_used;

    logic                     r_s1_valid;
    logic                     r_s1_circle;
    logic                     r_s1_last;
    logic signed [SCAN_W-1:0] r_s1_dx;
    logic signed [SCAN_W-1:0] r_s1_dy;

    logic                     r_s2_valid;
    logic                     r_s2_circle;
    logic                     r_s2_last;
    logic signed [PT_W-1:0]   r_s2_px;
    logic signed [PT_W-1:0]   r_s2_py;
    logic [SQ_W-1:0]          r_s2_sqx;
    logic [SQ_W-1:0]          r_s2_sqy;
    logic [SQ_W-1:0]          r_s2_sqr;

    logic                     r_s3_valid;
    logic                     r_s3_circle;
    logic                     r_s3_last;
    logic signed [PT_W-1:0]   r_s3_px;
    logic signed [PT_W-1:0]   r_s3_py;
    logic signed [DIFF_W-1:0] r_s3_diff;

    logic signed [2*SCAN_W-1:0] prod_x;
    logic signed [2*SCAN_W-1:0] prod_y;
    logic signed [DIFF_W-1:0]   n_diff;
    logic signed [DIFF_W-1:0]   band_s;
    logic                       in_band;

    assign rad = $signed({1'b0, i_cfg.radius});

    always_comb begin
        cur_phase = r_phase;
        cur_x     = r_scan_x;
        cur_y     = r_scan_y;
        if (i_start_req) begin
            cur_phase = PH_CIRCLE;
            cur_x     = -rad;
            cur_y     = -rad;
        end
        n_phase  = cur_phase;
        n_scan_x = cur_x;
        n_scan_y = cur_y;
        fin      = 1'b0;
        unique case (cur_phase)
            PH_CIRCLE: begin
                if (cur_y < rad) begin
                    n_scan_y = cur_y + SCAN_W'(1);
                end else begin
                    n_scan_y = -rad;
                    if (cur_x < rad) begin
                        n_scan_x = cur_x + SCAN_W'(1);
                    end else begin
                        n_phase  = PH_HSPOKE;
                        n_scan_x = -rad;
                        n_scan_y = '0;
                    end
                end
            end
            PH_HSPOKE: begin
                if (cur_x < rad) begin
                    n_scan_x = cur_x + SCAN_W'(1);
                end else begin
                    n_phase  = PH_VSPOKE;
                    n_scan_x = '0;
                    n_scan_y = -rad;
                end
            end
            PH_VSPOKE: begin
                fin = (cur_y >= rad);
                if (fin) begin
                    n_phase = PH_IDLE;
                end else begin
                    n_scan_y = cur_y + SCAN_W'(1);
                end
            end
            PH_IDLE: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // hold input while queued plus in-flight points could fill the queue
    assign credit_used = {1'b0, i_q_count} + (QCNT_W+1)'(r_s1_valid)
                       + (QCNT_W+1)'(r_s2_valid) + (QCNT_W+1)'(r_s3_valid);
    assign o_ready = (credit_used < (QCNT_W+1)'(QUEUE_DEPTH));
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_IDLE;
            r_scan_x   <= '0;
            r_scan_y   <= '0;
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_phase  <= n_phase;
                r_scan_x <= n_scan_x;
                r_scan_y <= n_scan_y;
            end
            r_s1_valid <= accept && (cur_phase != PH_IDLE);
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
        end
    end

    assign prod_x = r_s1_dx * r_s1_dx;
    assign prod_y = r_s1_dy * r_s1_dy;

    always_ff @(posedge i_clk) begin
        r_s1_circle <= (cur_phase == PH_CIRCLE);
        r_s1_last   <= fin;
        r_s1_dx     <= (cur_phase == PH_VSPOKE) ? '0 : cur_x;
        r_s1_dy     <= (cur_phase == PH_HSPOKE) ? '0 : cur_y;

        r_s2_circle <= r_s1_circle;
        r_s2_last   <= r_s1_last;
        r_s2_px     <= PT_W'(i_cfg.center_x) + PT_W'(r_s1_dx);
        r_s2_py     <= PT_W'(i_cfg.center_y) + PT_W'(r_s1_dy);
        r_s2_sqx    <= prod_x[SQ_W-1:0];
        r_s2_sqy    <= prod_y[SQ_W-1:0];
        r_s2_sqr    <= i_cfg.radius * i_cfg.radius;

        r_s3_circle <= r_s2_circle;
        r_s3_last   <= r_s2_last;
        r_s3_px     <= r_s2_px;
        r_s3_py     <= r_s2_py;
        r_s3_diff   <= n_diff;
    end

    assign n_diff  = DIFF_W'(r_s2_sqx) + DIFF_W'(r_s2_sqy) - DIFF_W'(r_s2_sqr);
    assign band_s  = DIFF_W'(i_cfg.band_half);
    assign in_band = (r_s3_diff < band_s) && (r_s3_diff > -band_s);

    assign o_push.valid     = r_s3_valid && (!r_s3_circle || in_band);
    assign o_push.data.px   = r_s3_px;
    assign o_push.data.py   = r_s3_py;
    assign o_push.data.last = r_s3_last;

endmodule

/* src/crbt_back.sv */
// Transform back end: Q-format rotate, truncate toward zero, offset and saturate.
// Three-stage pipeline ending in the output register; depends on crbt_pkg.
`timescale 1ns / 1ps

module crbt_back
    import crbt_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    input  logic                         i_q_empty,
    input  t_point                       i_q_data,
    output logic                         o_q_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic                         o_last
);

    localparam int PROD_W = PT_W + COEF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam int T_W    = SUM_W + 1;
    localparam logic signed [T_W-1:0] SAT_HI = T_W'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [T_W-1:0] SAT_LO = -SAT_HI - T_W'(1);

    logic                       en;

    logic                       r_m_valid;
    logic                       r_m_last;
    logic signed [PROD_W-1:0]   r_m_xc;
    logic signed [PROD_W-1:0]   r_m_ys;
    logic signed [PROD_W-1:0]   r_m_xs;
    logic signed [PROD_W-1:0]   r_m_yc;

    logic                       r_a_valid;
    logic                       r_a_last;
    logic signed [SUM_W-1:0]    r_a_sx;
    logic signed [SUM_W-1:0]    r_a_sy;

    logic                       r_o_valid;
    logic                       r_o_last;
    logic signed [COORD_BITS-1:0] r_o_x;
    logic signed [COORD_BITS-1:0] r_o_y;

    logic signed [COORD_BITS-1:0] n_o_x;
    logic signed [COORD_BITS-1:0] n_o_y;

    function automatic logic signed [COORD_BITS-1:0] to_coord(
        input logic signed [SUM_W-1:0]  s,
        input logic signed [OFS_W-1:0]  ofs
    );
        logic signed [SUM_W-1:0] q;
        logic signed [T_W-1:0]   cin;
        logic signed [T_W-1:0]   t;
        logic signed [T_W-1:0]   r;
        q   = s >>> FRAC_BITS;
        cin = {{(T_W-1){1'b0}}, (s[SUM_W-1] && (s[FRAC_BITS-1:0] != '0))};
        t   = T_W'(q) + T_W'(ofs) + cin;
        if (t > SAT_HI) begin
            r = SAT_HI;
        end else if (t < SAT_LO) begin
            r = SAT_LO;
        end else begin
            r = t;
        end
        return r[COORD_BITS-1:0];
    endfunction

    assign en      = !r_o_valid || i_ready;
    assign o_q_pop = en && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_m_valid <= !i_q_empty;
            r_a_valid <= r_m_valid;
            r_o_valid <= r_a_valid;
        end
    end

    assign n_o_x = to_coord(r_a_sx, i_cfg.offset_x);
    assign n_o_y = to_coord(r_a_sy, i_cfg.offset_y);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m_last <= i_q_data.last;
            r_m_xc   <= i_q_data.px * i_cfg.cos_q;
            r_m_ys   <= i_q_data.py * i_cfg.sin_q;
            r_m_xs   <= i_q_data.px * i_cfg.sin_q;
            r_m_yc   <= i_q_data.py * i_cfg.cos_q;

            r_a_last <= r_m_last;
            r_a_sx   <= SUM_W'(r_m_xc) - SUM_W'(r_m_ys);
            r_a_sy   <= SUM_W'(r_m_xs) + SUM_W'(r_m_yc);

            r_o_last <= r_a_last;
            r_o_x    <= n_o_x;
            r_o_y    <= n_o_y;
        end
    end

    assign o_valid   = r_o_valid;
    assign o_pixel_x = r_o_x;
    assign o_pixel_y = r_o_y;
    assign o_last    = r_o_last;

endmodule

/* src/circle_band_raster_transform.sv */
// Top level of the circle and spoke raster generator with rotate and translate.
// Holds the configuration registers; instantiates crbt_front, crbt_queue, crbt_back.
//
//  Channel   Signals                               Direction
//  input     i_valid / o_ready, i_start_req        in
//  result    o_valid / i_ready, o_pixel_*, o_last  out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data       in, write only
//
// One transaction per cycle in and out while both sides keep flowing.
// A result passes the front-end stages, the point queue and the transform stages
// before it is presented at the outputs. The input stalls once queued and in-flight
// points reach eight; output stalls hold the transform pipeline, and the front end
// stalls in turn once its queue credit runs out. Reset is synchronous; no clearing pass.
`timescale 1ns / 1ps

module circle_band_raster_transform
    import crbt_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 14
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_start_req,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [COORD_BITS-1:0] o_pixel_x,
    output logic signed [COORD_BITS-1:0] o_pixel_y,
    output logic                         o_last,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data
);

    t_cfg              r_cfg;
    t_push             q_push;
    logic              q_pop;
    t_point            q_data;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.center_x  <= '0;
            r_cfg.center_y  <= '0;
            r_cfg.radius    <= '0;
            r_cfg.band_half <= BAND_RESET;
            r_cfg.cos_q     <= COS_RESET;
            r_cfg.sin_q     <= '0;
            r_cfg.offset_x  <= '0;
            r_cfg.offset_y  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_CENTER_X:  r_cfg.center_x  <= i_cfg_data[CX_W-1:0];
                CFG_CENTER_Y:  r_cfg.center_y  <= i_cfg_data[CX_W-1:0];
                CFG_RADIUS:    r_cfg.radius    <= i_cfg_data[R_W-1:0];
                CFG_BAND_HALF: r_cfg.band_half <= i_cfg_data[BAND_W-1:0];
                CFG_COS_Q:     r_cfg.cos_q     <= i_cfg_data[COEF_W-1:0];
                CFG_SIN_Q:     r_cfg.sin_q     <= i_cfg_data[COEF_W-1:0];
                CFG_OFFSET_X:  r_cfg.offset_x  <= i_cfg_data[OFS_W-1:0];
                CFG_OFFSET_Y:  r_cfg.offset_y  <= i_cfg_data[OFS_W-1:0];
            endcase
        end
    end

    crbt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_start_req (i_start_req),
        .i_q_count   (q_count),
        .o_push      (q_push)
    );

    crbt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    crbt_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_pixel_x (o_pixel_x),
        .o_pixel_y (o_pixel_y),
        .o_last    (o_last)
    );

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_push.valid && !q_pop) |-> (q_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("point queue overflow");

    a_queue_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("point queue popped while empty");

    a_ready_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count == QCNT_W'(QUEUE_DEPTH)) |-> !o_ready)
        else $error("input ready with full point queue");

endmodule

/* bench/tb_top.sv */
// Self-checking testbench for circle_band_raster_transform.
// Drives a directed table and then random walks through the valid/ready channels, checking
// every pixel against an in-bench raster and transform predictor. Depends on crbt_pkg.
`timescale 1ns / 1ps

module tb_top
    import crbt_pkg::*;
();

    localparam int     CYCLE_LIMIT = 1_000_000;
    localparam int     WALK_TARGET = 1300;
    localparam longint Q_ONE       = 1 << 14;
    localparam longint PIX_MAX     = 2047;
    localparam longint PIX_MIN     = -2048;

    typedef enum logic [1:0] {
        ROW_CFG   = 2'd0,
        ROW_PRED  = 2'd1,
        ROW_NONE  = 2'd2,
        ROW_POINT = 2'd3
    } t_row_kind;

    typedef struct packed {
        t_row_kind              kind;
        t_cfg_idx               idx;
        logic [CFG_DATA_W-1:0]  data;
        logic                   start;
        t_point                 pt;
    } t_dir_row;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic                    i_start_req = 1'b0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic signed [PT_W-1:0]  o_pixel_x;
    logic signed [PT_W-1:0]  o_pixel_y;
    logic                    o_last;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;

    // Predictor copy of the registers and the walk.
    int     c_cx = 0;
    int     c_cy = 0;
    int     c_r = 0;
    int     c_band = 125;
    int     c_cos = 16384;
    int     c_sin = 0;
    int     c_ox = 0;
    int     c_oy = 0;
    t_phase walk_ph = PH_IDLE;
    int     walk_dx = 0;
    int     walk_dy = 0;

    t_point   pending_pixels[$];
    t_dir_row dir_tab[$];
    int       walk_items = 0;
    int       bad_pixels = 0;
    bit       send_steady = 1'b0;

    circle_band_raster_transform i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_start_req (i_start_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_pixel_x   (o_pixel_x),
        .o_pixel_y   (o_pixel_y),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    function automatic longint clamp_pix(longint v);
        if (v > PIX_MAX) return PIX_MAX;
        if (v < PIX_MIN) return PIX_MIN;
        return v;
    endfunction

    function automatic t_point place(int px, int py, bit fin);
        longint rx;
        longint ry;
        t_point p;
        rx = longint'(px) * c_cos - longint'(py) * c_sin;
        ry = longint'(px) * c_sin + longint'(py) * c_cos;
        p.px = PT_W'(clamp_pix(rx / Q_ONE + c_ox));
        p.py = PT_W'(clamp_pix(ry / Q_ONE + c_oy));
        p.last = fin;
        return p;
    endfunction

    task automatic next_pixel(input bit start, output bit hit, output t_point pt);
        longint d2;
        longint dev;
        hit = 1'b0;
        pt = '0;
        if (start) begin
            walk_ph = PH_CIRCLE;
            walk_dx = -c_r;
            walk_dy = -c_r;
        end
        case (walk_ph)
            PH_CIRCLE: begin
                d2 = longint'(walk_dx) * walk_dx + longint'(walk_dy) * walk_dy;
                dev = d2 - longint'(c_r) * c_r;
                if (dev < 0) dev = -dev;
                if (dev < c_band) begin
                    hit = 1'b1;
                    pt = place(c_cx + walk_dx, c_cy + walk_dy, 1'b0);
                end
                if (walk_dy < c_r) begin
                    walk_dy++;
                end else begin
                    walk_dy = -c_r;
                    if (walk_dx < c_r) begin
                        walk_dx++;
                    end else begin
                        walk_ph = PH_HSPOKE;
                        walk_dx = -c_r;
                        walk_dy = 0;
                    end
                end
            end
            PH_HSPOKE: begin
                hit = 1'b1;
                pt = place(c_cx + walk_dx, c_cy, 1'b0);
                if (walk_dx < c_r) begin
                    walk_dx++;
                end else begin
                    walk_ph = PH_VSPOKE;
                    walk_dx = 0;
                    walk_dy = -c_r;
                end
            end
            PH_VSPOKE: begin
                hit = 1'b1;
                pt = place(c_cx, c_cy + walk_dy, walk_dy >= c_r);
                if (walk_dy >= c_r) walk_ph = PH_IDLE;
                else walk_dy++;
            end
            default: ;
        endcase
    endtask

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pick_radius();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60) return $urandom_range(0, 3);
        if (p < 90) return $urandom_range(4, 7);
        if (p < 97) return $urandom_range(8, 12);
        if (p < 99) return 511;
        return $urandom_range(13, 511);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_band();
        int p;
        p = $urandom_range(0, 99);
        if (p < 10) return '0;
        if (p < 20) return '1;
        if (p < 85) return CFG_DATA_W'($urandom_range(1, 4 * c_r + 4));
        return CFG_DATA_W'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_reg(t_cfg_idx idx);
        int p;
        int v;
        p = $urandom_range(0, 99);
        v = $urandom;
        case (idx)
            CFG_CENTER_X, CFG_CENTER_Y: begin
                if (p < 15) v = -1024;
                else if (p < 30) v = 1023;
                else if (p < 70) v = $urandom_range(0, 200) - 100;
            end
            CFG_COS_Q, CFG_SIN_Q: begin
                if (p < 15) v = -16384;
                else if (p < 30) v = 16384;
                else if (p < 70) v = $urandom_range(0, 32768) - 16384;
            end
            CFG_OFFSET_X, CFG_OFFSET_Y: begin
                if (p < 15) v = -2048;
                else if (p < 30) v = 2047;
                else if (p < 70) v = $urandom_range(0, 200) - 100;
            end
            default: ;
        endcase
        return CFG_DATA_W'(v);
    endfunction

    function automatic t_dir_row cfg_row(t_cfg_idx idx, int v);
        t_dir_row r;
        r = '0;
        r.kind = ROW_CFG;
        r.idx = idx;
        r.data = CFG_DATA_W'(v);
        return r;
    endfunction

    function automatic t_dir_row item_row(t_row_kind kind, bit start, int x, int y, bit fin);
        t_dir_row r;
        r = '0;
        r.kind = kind;
        r.start = start;
        r.pt.px = PT_W'(x);
        r.pt.py = PT_W'(y);
        r.pt.last = fin;
        return r;
    endfunction

    task automatic cfg_write(t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            CFG_CENTER_X:  c_cx = int'($signed(data[CX_W-1:0]));
            CFG_CENTER_Y:  c_cy = int'($signed(data[CX_W-1:0]));
            CFG_RADIUS:    c_r = int'(data[R_W-1:0]);
            CFG_BAND_HALF: c_band = int'(data);
            CFG_COS_Q:     c_cos = int'($signed(data));
            CFG_SIN_Q:     c_sin = int'($signed(data));
            CFG_OFFSET_X:  c_ox = int'($signed(data[OFS_W-1:0]));
            CFG_OFFSET_Y:  c_oy = int'($signed(data[OFS_W-1:0]));
            default: ;
        endcase
    endtask

    // Offer one transaction, record its expectation on acceptance, then idle for a random gap unless sending steadily.
    task automatic send_item(input bit start, input t_row_kind kind, input t_point typed);
        bit     hit;
        t_point pt;
        int     g;
        i_valid <= 1'b1;
        i_start_req <= start;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (walk_ph != PH_IDLE || start) walk_items++;
        next_pixel(start, hit, pt);
        if (kind == ROW_POINT) pending_pixels.push_back(typed);
        else if (kind == ROW_PRED && hit) pending_pixels.push_back(pt);
        g = send_steady ? 0 : pick_gap();
        if (g > 0) begin
            i_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // Drain all pixels, then let the pipeline empty out before touching registers.
    task automatic settle();
        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    function automatic int walk_span();
        int w;
        w = 2 * c_r + 1;
        w = w * w + 2 * w + $urandom_range(0, 3);
        return (w > 400) ? 400 : w;
    endfunction

    initial begin
        bit        writing;
        bit        restart;
        bit        wr;
        int        len;
        t_cfg_idx  ri;
        logic [CFG_DATA_W-1:0] val;

        dir_tab.push_back(item_row(ROW_NONE, 1'b0, 0, 0, 1'b0));
        dir_tab.push_back(item_row(ROW_POINT, 1'b1, 0, 0, 1'b0));
        dir_tab.push_back(item_row(ROW_POINT, 1'b0, 0, 0, 1'b0));
        dir_tab.push_back(item_row(ROW_POINT, 1'b0, 0, 0, 1'b1));
        dir_tab.push_back(item_row(ROW_NONE, 1'b0, 0, 0, 1'b0));
        dir_tab.push_back(cfg_row(CFG_CENTER_X, 1023));
        dir_tab.push_back(cfg_row(CFG_CENTER_Y, -1024));
        dir_tab.push_back(cfg_row(CFG_OFFSET_X, 2047));
        dir_tab.push_back(cfg_row(CFG_OFFSET_Y, -2048));
        dir_tab.push_back(item_row(ROW_POINT, 1'b1, 2047, -2048, 1'b0));
        dir_tab.push_back(item_row(ROW_POINT, 1'b0, 2047, -2048, 1'b0));
        dir_tab.push_back(item_row(ROW_POINT, 1'b0, 2047, -2048, 1'b1));
        dir_tab.push_back(cfg_row(CFG_CENTER_X, 0));
        dir_tab.push_back(cfg_row(CFG_CENTER_Y, 0));
        dir_tab.push_back(cfg_row(CFG_OFFSET_X, 0));
        dir_tab.push_back(cfg_row(CFG_OFFSET_Y, 0));
        dir_tab.push_back(cfg_row(CFG_RADIUS, 1));
        dir_tab.push_back(cfg_row(CFG_BAND_HALF, 0));
        dir_tab.push_back(cfg_row(CFG_COS_Q, -16384));
        dir_tab.push_back(cfg_row(CFG_SIN_Q, 16384));
        // zero band: every circle candidate is rejected
        dir_tab.push_back(item_row(ROW_NONE, 1'b1, 0, 0, 1'b0));
        repeat (8) dir_tab.push_back(item_row(ROW_NONE, 1'b0, 0, 0, 1'b0));
        repeat (6) dir_tab.push_back(item_row(ROW_PRED, 1'b0, 0, 0, 1'b0));
        dir_tab.push_back(cfg_row(CFG_RADIUS, 511));
        dir_tab.push_back(cfg_row(CFG_BAND_HALF, 65535));
        dir_tab.push_back(cfg_row(CFG_SIN_Q, -16384));
        dir_tab.push_back(item_row(ROW_NONE, 1'b1, 0, 0, 1'b0));
        dir_tab.push_back(item_row(ROW_NONE, 1'b0, 0, 0, 1'b0));

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        writing = 1'b0;
        foreach (dir_tab[k]) begin
            if (dir_tab[k].kind == ROW_CFG) begin
                if (!writing) begin
                    settle();
                    writing = 1'b1;
                end
                cfg_write(dir_tab[k].idx, dir_tab[k].data);
            end else begin
                if (writing) begin
                    i_cfg_we <= 1'b0;
                    writing = 1'b0;
                end
                send_item(dir_tab[k].start, dir_tab[k].kind, dir_tab[k].pt);
            end
        end

        while (walk_items < WALK_TARGET) begin
            settle();
            restart = $urandom_range(0, 9) < 8;
            send_steady = $urandom_range(0, 3) == 0;
            for (int k = 0; k < 8; k++) begin
                ri = t_cfg_idx'(k);
                if (ri == CFG_RADIUS) begin
                    wr = $urandom_range(0, 99) < 85;
                    val = CFG_DATA_W'(pick_radius());
                end else if (ri == CFG_BAND_HALF) begin
                    wr = $urandom_range(0, 99) < 50;
                    val = pick_band();
                end else begin
                    wr = $urandom_range(0, 99) < 35;
                    val = pick_reg(ri);
                end
                if (wr) cfg_write(ri, val);
            end
            i_cfg_we <= 1'b0;
            len = (restart && $urandom_range(0, 99) < 85) ? walk_span() : $urandom_range(1, 60);
            for (int n = 0; n < len && walk_items < WALK_TARGET; n++)
                send_item((n == 0 && restart) || $urandom_range(0, 99) == 0, ROW_PRED, '0);
        end

        i_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (bad_pixels == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Result side: check each transaction, stall at random, hold off now and then.
    initial begin
        int     stall_left;
        int     hold_left;
        int     hold_at;
        int     ticks;
        bit     calm;
        t_point want;

        stall_left = 0;
        hold_left = 0;
        hold_at = 300;
        ticks = 0;
        calm = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready) begin
                if (pending_pixels.size() == 0) begin
                    bad_pixels++;
                    if (bad_pixels <= 10)
                        $display("unexpected pixel x=%0d y=%0d last=%0b",
                                 o_pixel_x, o_pixel_y, o_last);
                end else begin
                    want = pending_pixels.pop_front();
                    if (o_pixel_x !== want.px || o_pixel_y !== want.py
                            || o_last !== want.last) begin
                        bad_pixels++;
                        if (bad_pixels <= 10)
                            $display("mismatch exp %0d %0d %0b got %0d %0d %0b",
                                     want.px, want.py, want.last,
                                     o_pixel_x, o_pixel_y, o_last);
                    end
                end
            end
            ticks++;
            if (ticks % 128 == 0) calm = $urandom_range(0, 2) == 0;
            if (hold_left == 0 && walk_items >= hold_at) begin
                hold_left = 150;
                hold_at += 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

endmodule

/* files.f */
src/crbt_pkg.sv
src/crbt_queue.sv
src/crbt_front.sv
src/crbt_back.sv
src/circle_band_raster_transform.sv
bench/tb_top.sv
